// ----- rtl/ade_pkg.sv -----
package ade_pkg;

  localparam int BITMAP_DEPTH = 6144;
  localparam int ATTR_DEPTH   = 768;
  localparam int VM_DEPTH     = 6912;
  localparam int SCREEN_ROWS  = 192;

  localparam int VM_AW     = 13;
  localparam int BITMAP_AW = $clog2(BITMAP_DEPTH);
  localparam int ATTR_AW   = $clog2(ATTR_DEPTH);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  // one input word as the video memory sees it
  typedef struct packed {
    logic             wr;
    logic             rd;
    logic [VM_AW-1:0] addr;
    logic [7:0]       data;
    logic [7:0]       px;
    logic [7:0]       py;
  } vm_req_t;

  // side information travelling with a pixel while the memory answers
  typedef struct packed {
    logic [2:0] px_lo;
    logic       phase;
    logic       row_ok;
  } pix_info_t;

  typedef struct packed {
    logic [4:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_out_t;

  function automatic logic [23:0] pal_rgb(input logic [4:0] idx);
    logic [23:0] c;
    case (idx)
      5'd0:  c = {8'd0,   8'd0,   8'd0};
      5'd1:  c = {8'd0,   8'd0,   8'd192};
      5'd2:  c = {8'd192, 8'd0,   8'd0};
      5'd3:  c = {8'd192, 8'd0,   8'd192};
      5'd4:  c = {8'd0,   8'd192, 8'd0};
      5'd5:  c = {8'd0,   8'd192, 8'd192};
      5'd6:  c = {8'd192, 8'd192, 8'd0};
      5'd7:  c = {8'd192, 8'd192, 8'd192};
      5'd8:  c = {8'd0,   8'd0,   8'd0};
      5'd9:  c = {8'd96,  8'd96,  8'd255};
      5'd10: c = {8'd255, 8'd96,  8'd96};
      5'd11: c = {8'd255, 8'd96,  8'd255};
      5'd12: c = {8'd96,  8'd255, 8'd96};
      5'd13: c = {8'd96,  8'd255, 8'd255};
      5'd14: c = {8'd255, 8'd255, 8'd96};
      5'd15: c = {8'd255, 8'd255, 8'd255};
      5'd16: c = {8'd120, 8'd90,  8'd40};
      5'd17: c = {8'd70,  8'd80,  8'd192};
      5'd18: c = {8'd75,  8'd0,   8'd255};
      5'd19: c = {8'd20,  8'd30,  8'd86};
      5'd20: c = {8'd90,  8'd255, 8'd0};
      5'd21: c = {8'd70,  8'd50,  8'd10};
      5'd22: c = {8'd0,   8'd255, 8'd0};
      5'd23: c = {8'd56,  8'd45,  8'd120};
      5'd24: c = {8'd255, 8'd10,  8'd70};
      5'd25: c = {8'd50,  8'd25,  8'd80};
      5'd26: c = {8'd255, 8'd96,  8'd96};
      5'd27: c = {8'd255, 8'd96,  8'd255};
      5'd28: c = {8'd96,  8'd255, 8'd96};
      5'd29: c = {8'd60,  8'd255, 8'd70};
      5'd30: c = {8'd32,  8'd255, 8'd96};
      5'd31: c = {8'd255, 8'd255, 8'd255};
      default: c = 24'd0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/ade_ram.sv -----
module ade_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ade_vmem.sv -----
module ade_vmem (
  input  logic           clk,
  input  ade_pkg::vm_req_t req,
  output logic [7:0]     bits,
  output logic [7:0]     attr
);
  import ade_pkg::*;

  logic                 bm_we;
  logic                 at_we;
  logic                 row_ok;
  logic                 rd_en;
  logic [VM_AW-1:0]     at_off;
  logic [BITMAP_AW-1:0] bm_raddr;
  logic [ATTR_AW-1:0]   at_raddr;

  always_comb begin
    bm_we  = req.wr && (req.addr < VM_AW'(BITMAP_DEPTH));
    at_we  = req.wr && (req.addr >= VM_AW'(BITMAP_DEPTH)) && (req.addr < VM_AW'(VM_DEPTH));
    at_off = req.addr - VM_AW'(BITMAP_DEPTH);
    row_ok = req.py < 8'(SCREEN_ROWS);
    rd_en  = req.rd && row_ok;
    // third, line in cell, cell row, column
    bm_raddr = BITMAP_AW'({req.py[7:6], req.py[2:0], req.py[5:3], req.px[7:3]});
    at_raddr = ATTR_AW'({req.py[7:3], req.px[7:3]});
  end

  ade_ram #(
    .WIDTH (8),
    .DEPTH (BITMAP_DEPTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (req.addr[BITMAP_AW-1:0]),
    .wdata (req.data),
    .re    (rd_en),
    .raddr (bm_raddr),
    .rdata (bits)
  );

  ade_ram #(
    .WIDTH (8),
    .DEPTH (ATTR_DEPTH)
  ) u_attr (
    .clk   (clk),
    .we    (at_we),
    .waddr (at_off[ATTR_AW-1:0]),
    .wdata (req.data),
    .re    (rd_en),
    .raddr (at_raddr),
    .rdata (attr)
  );

endmodule

// ----- rtl/ade_color.sv -----
module ade_color (
  input  logic               [7:0] bits,
  input  logic               [7:0] attr,
  input  ade_pkg::pix_info_t       info,
  input  logic               [4:0] offset,
  output ade_pkg::pix_out_t        pix
);
  import ade_pkg::*;

  logic [7:0]  b;
  logic [7:0]  a;
  logic        dot;
  logic [3:0]  base;
  logic [4:0]  idx;
  logic [23:0] rgb;

  always_comb begin
    // rows below the screen read as blank
    b    = info.row_ok ? bits : 8'd0;
    a    = info.row_ok ? attr : 8'd0;
    dot  = b[~info.px_lo] ^ (info.phase & a[7]);
    base = {a[6], (dot ? a[2:0] : a[5:3])};
    idx  = {1'b0, base} + offset;
    rgb  = pal_rgb(idx);
    pix.idx   = idx;
    pix.red   = rgb[23:16];
    pix.green = rgb[15:8];
    pix.blue  = rgb[7:0];
  end

endmodule

// ----- rtl/attribute_display_pixel_engine.sv -----
// channel  direction  handshake        word
// in       input      in_valid/stall   cmd, mem_addr, mem_data, pixel_x, pixel_y, flash_phase
// out      output     out_valid/stall  color_index, red, green, blue
// cfg      input      cfg_valid/ready  cfg_data = palette_offset
//
// one word per cycle while in_stall is low; a pixel reads the memories when it is taken,
// and the memory outputs and its side information then load the output register;
// writes give no result and land in memory at the edge they are taken
// rst_n is synchronous and clears the pipeline and the offset, not the memories
// in_stall rises only while a pixel waits behind a stalled output word
module attribute_display_pixel_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [12:0] in_mem_addr,
  input  logic [7:0]  in_mem_data,
  input  logic [7:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,
  input  logic        in_flash_phase,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_color_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);
  import ade_pkg::*;

  logic      in_accept;
  logic      pix_accept;
  logic      out_load;
  vm_req_t   req;
  logic [7:0] bits;
  logic [7:0] attr;
  pix_out_t  pix;

  logic      s1_valid_r, s1_valid_nxt;
  pix_info_t s1_info_r;
  logic      out_valid_r, out_valid_nxt;
  pix_out_t  out_r;
  logic [4:0] offset_r;

  always_comb begin
    in_stall   = s1_valid_r && out_valid_r && out_stall;
    in_accept  = in_valid && !in_stall;
    pix_accept = in_accept && (cmd_t'(in_cmd) == CMD_PIXEL);
    out_load   = s1_valid_r && (!out_valid_r || !out_stall);
    s1_valid_nxt  = pix_accept || (s1_valid_r && !out_load);
    out_valid_nxt = out_load || (out_valid_r && out_stall);

    req.wr   = in_accept && (cmd_t'(in_cmd) == CMD_WRITE);
    req.rd   = pix_accept;
    req.addr = in_mem_addr;
    req.data = in_mem_data;
    req.px   = in_pixel_x;
    req.py   = in_pixel_y;
  end

  ade_vmem u_vmem (
    .clk  (clk),
    .req  (req),
    .bits (bits),
    .attr (attr)
  );

  ade_color u_color (
    .bits   (bits),
    .attr   (attr),
    .info   (s1_info_r),
    .offset (offset_r),
    .pix    (pix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      offset_r    <= 5'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        offset_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_info_r.px_lo  <= in_pixel_x[2:0];
      s1_info_r.phase  <= in_flash_phase;
      s1_info_r.row_ok <= in_pixel_y < 8'(SCREEN_ROWS);
    end
    if (out_load) begin
      out_r <= pix;
    end
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_color_index = out_r.idx;
  assign out_red         = out_r.red;
  assign out_green       = out_r.green;
  assign out_blue        = out_r.blue;

endmodule

// ----- rtl/ade_checker.sv -----
module ade_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [4:0] out_color_index,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_color_index) && $stable(out_red))
    else $error("stalled output word changed");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // colour follows the index: white entry
  a_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_color_index == 5'd15 |->
      out_red == 8'd255 && out_green == 8'd255 && out_blue == 8'd255)
    else $error("palette entry fifteen wrong");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind attribute_display_pixel_engine ade_checker u_ade_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_color_index (out_color_index),
  .out_red         (out_red),
  .out_green       (out_green),
  .out_blue        (out_blue)
);
